/* src/fssb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssb_pkg
// Shared widths, codes and register indexes of the flow sample statistics
// block with burst detection.
// ----------------------------------------------------------------------------
package fssb_pkg;

    localparam int TIME_BITS_DEF = 48;

    localparam int STAMP_W    = 48;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 32;
    localparam int VAL_W      = 48;
    localparam int IDX_W      = 4;
    localparam int NUM_STATS  = 14;
    localparam int IN_DATA_W  = STAMP_W + LEN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // item kind
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BURST_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_BYTES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_GAPS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_BURSTS   = 3'd5;

    // statistic indexes in readout order
    localparam logic [IDX_W-1:0] STAT_PACKETS   = 4'd0;
    localparam logic [IDX_W-1:0] STAT_BYTE_SUM  = 4'd1;
    localparam logic [IDX_W-1:0] STAT_BYTE_MIN  = 4'd2;
    localparam logic [IDX_W-1:0] STAT_BYTE_MAX  = 4'd3;
    localparam logic [IDX_W-1:0] STAT_GAP_SUM   = 4'd4;
    localparam logic [IDX_W-1:0] STAT_GAP_MIN   = 4'd5;
    localparam logic [IDX_W-1:0] STAT_GAP_MAX   = 4'd6;
    localparam logic [IDX_W-1:0] STAT_BURSTS    = 4'd7;
    localparam logic [IDX_W-1:0] STAT_SIZE_SUM  = 4'd8;
    localparam logic [IDX_W-1:0] STAT_SIZE_MIN  = 4'd9;
    localparam logic [IDX_W-1:0] STAT_SIZE_MAX  = 4'd10;
    localparam logic [IDX_W-1:0] STAT_TIME_SUM  = 4'd11;
    localparam logic [IDX_W-1:0] STAT_TIME_MIN  = 4'd12;
    localparam logic [IDX_W-1:0] STAT_TIME_MAX  = 4'd13;

    typedef logic [VAL_W-1:0] t_val;

endpackage

/* src/flow_sample_stats_burst_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_sample_stats_burst_top
// Per-window flow statistics: packet count, byte and inter-arrival gap
// sum/min/max, and burst count, size and duration with a burst detector.
// A close beat reads out the fourteen statistics and clears them.
// ----------------------------------------------------------------------------
// path: an item is taken into the input register and updates the statistics
//   from it; a close waits in it for a free readout, then loads the shift line
// throughput: one item per cycle unless a close waits; a close holds the readout
//   shift line for fourteen beats, a later close waits till its last beat leaves
// reset: synchronous, active low; clears all statistics and burst state and
//   loads the configuration registers with their reset values
module flow_sample_stats_burst_top #(
    parameter int TIME_BITS = fssb_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fssb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fssb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // item stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fssb_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // stamp[47:0], length[63:48]
    input  logic                                s_axis_tuser,  // op[0]
    // statistics stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fssb_pkg::VAL_W-1:0]          m_axis_tdata,  // stat_value[47:0]
    output logic [fssb_pkg::IDX_W-1:0]          m_axis_tuser,  // stat_index[3:0]
    output logic                                m_axis_tlast
);

    localparam int TW = TIME_BITS;

    // configuration
    logic [fssb_pkg::CNT_W-1:0] r_burst_threshold;
    logic [TW-1:0]              r_short_gap;
    logic [TW-1:0]              r_long_gap;
    logic                       r_en_bytes;
    logic                       r_en_gaps;
    logic                       r_en_bursts;

    // input register
    logic                           r_in_valid;
    logic                           r_in_op;
    logic [fssb_pkg::STAMP_W-1:0]   r_in_stamp;
    logic [fssb_pkg::LEN_W-1:0]     r_in_len;

    // statistics state
    logic [fssb_pkg::CNT_W-1:0] r_pkt_count,  n_pkt_count;
    logic [fssb_pkg::CNT_W-1:0] r_byte_sum,   n_byte_sum;
    logic [fssb_pkg::LEN_W-1:0] r_byte_min,   n_byte_min;
    logic [fssb_pkg::LEN_W-1:0] r_byte_max,   n_byte_max;
    logic [TW-1:0]              r_last_arr,   n_last_arr;
    logic [TW-1:0]              r_gap_sum,    n_gap_sum;
    logic [TW-1:0]              r_gap_min,    n_gap_min;
    logic [TW-1:0]              r_gap_max,    n_gap_max;
    logic [fssb_pkg::CNT_W-1:0] r_bst_count,  n_bst_count;
    logic [fssb_pkg::CNT_W-1:0] r_size_sum,   n_size_sum;
    logic [fssb_pkg::CNT_W-1:0] r_size_min,   n_size_min;
    logic [fssb_pkg::CNT_W-1:0] r_size_max,   n_size_max;
    logic [TW-1:0]              r_time_sum,   n_time_sum;
    logic [TW-1:0]              r_time_min,   n_time_min;
    logic [TW-1:0]              r_time_max,   n_time_max;
    logic [TW-1:0]              r_open_start, n_open_start;
    logic [TW-1:0]              r_open_latest, n_open_latest;
    logic [fssb_pkg::CNT_W-1:0] r_open_size,  n_open_size;
    logic                       r_open_active, n_open_active;

    // burst close result
    logic [fssb_pkg::CNT_W-1:0] e_bst_count;
    logic [fssb_pkg::CNT_W-1:0] e_size_sum;
    logic [fssb_pkg::CNT_W-1:0] e_size_min;
    logic [fssb_pkg::CNT_W-1:0] e_size_max;
    logic [TW-1:0]              e_time_sum;
    logic [TW-1:0]              e_time_min;
    logic [TW-1:0]              e_time_max;

    // readout
    logic                           r_rd_busy;
    logic [fssb_pkg::IDX_W-1:0]     r_rd_cnt;
    fssb_pkg::t_val                 r_snap [fssb_pkg::NUM_STATS];
    fssb_pkg::t_val                 w_vals [fssb_pkg::NUM_STATS];

    logic w_fire;
    logic w_close;
    logic w_snap_free;
    logic w_beat_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_threshold <= '0;
            r_short_gap       <= '0;
            r_long_gap        <= '0;
            r_en_bytes        <= 1'b1;
            r_en_gaps         <= 1'b1;
            r_en_bursts       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fssb_pkg::REG_BURST_THRESHOLD: begin
                    r_burst_threshold <= i_cfg_data[fssb_pkg::CNT_W-1:0];
                end
                fssb_pkg::REG_SHORT_GAP:     r_short_gap <= TW'(i_cfg_data);
                fssb_pkg::REG_LONG_GAP:      r_long_gap  <= TW'(i_cfg_data);
                fssb_pkg::REG_ENABLE_BYTES:  r_en_bytes  <= i_cfg_data[0];
                fssb_pkg::REG_ENABLE_GAPS:   r_en_gaps   <= i_cfg_data[0];
                fssb_pkg::REG_ENABLE_BURSTS: r_en_bursts <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake of the update stage
    assign w_beat_out  = r_rd_busy && m_axis_tready;
    assign w_snap_free = !r_rd_busy
                         || (m_axis_tready && r_rd_cnt == fssb_pkg::STAT_TIME_MAX);
    assign w_fire      = r_in_valid && (r_in_op == fssb_pkg::OP_PACKET || w_snap_free);
    assign w_close     = w_fire && r_in_op == fssb_pkg::OP_CLOSE;
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op    <= s_axis_tuser;
            r_in_stamp <= s_axis_tdata[fssb_pkg::STAMP_W-1:0];
            r_in_len   <= s_axis_tdata[fssb_pkg::IN_DATA_W-1:fssb_pkg::STAMP_W];
        end
    end

    // burst close: folds the open burst into the burst statistics
    always_comb begin
        logic [TW-1:0] dur;
        dur        = r_open_latest - r_open_start;
        e_bst_count = r_bst_count;
        e_size_sum  = r_size_sum;
        e_size_min  = r_size_min;
        e_size_max  = r_size_max;
        e_time_sum  = r_time_sum;
        e_time_min  = r_time_min;
        e_time_max  = r_time_max;
        if (r_open_active) begin
            if (r_bst_count == '0) begin
                e_time_sum = dur;
                e_time_min = dur;
                e_time_max = dur;
                e_size_sum = r_open_size;
                e_size_min = r_open_size;
                e_size_max = r_open_size;
            end else begin
                e_time_sum = r_time_sum + dur;
                if (dur < r_time_min) begin
                    e_time_min = dur;
                end else if (dur > r_time_max) begin
                    e_time_max = dur;
                end
                e_size_sum = r_size_sum + r_open_size;
                if (r_open_size < r_size_min) begin
                    e_size_min = r_open_size;
                end else if (r_open_size > r_size_max) begin
                    e_size_max = r_open_size;
                end
            end
            e_bst_count = r_bst_count + 1'b1;
        end
    end

    // statistics update
    always_comb begin
        logic [TW-1:0]              now;
        logic [TW-1:0]              gap;
        logic [fssb_pkg::CNT_W-1:0] len32;
        logic [fssb_pkg::CNT_W-1:0] grown;
        logic                       first;
        now   = TW'(r_in_stamp);
        gap   = now - r_last_arr;
        len32 = fssb_pkg::CNT_W'(r_in_len);
        grown = r_open_size + len32;
        first = r_pkt_count == '0;

        n_pkt_count   = r_pkt_count;
        n_byte_sum    = r_byte_sum;
        n_byte_min    = r_byte_min;
        n_byte_max    = r_byte_max;
        n_last_arr    = r_last_arr;
        n_gap_sum     = r_gap_sum;
        n_gap_min     = r_gap_min;
        n_gap_max     = r_gap_max;
        n_bst_count   = r_bst_count;
        n_size_sum    = r_size_sum;
        n_size_min    = r_size_min;
        n_size_max    = r_size_max;
        n_time_sum    = r_time_sum;
        n_time_min    = r_time_min;
        n_time_max    = r_time_max;
        n_open_start  = r_open_start;
        n_open_latest = r_open_latest;
        n_open_size   = r_open_size;
        n_open_active = r_open_active;

        if (w_close) begin
            n_pkt_count   = '0;
            n_byte_sum    = '0;
            n_byte_min    = '0;
            n_byte_max    = '0;
            n_last_arr    = '0;
            n_gap_sum     = '0;
            n_gap_min     = '0;
            n_gap_max     = '0;
            n_bst_count   = '0;
            n_size_sum    = '0;
            n_size_min    = '0;
            n_size_max    = '0;
            n_time_sum    = '0;
            n_time_min    = '0;
            n_time_max    = '0;
            n_open_start  = '0;
            n_open_latest = '0;
            n_open_size   = '0;
            n_open_active = 1'b0;
        end else if (w_fire) begin
            if (r_en_bytes) begin
                if (first) begin
                    n_byte_sum = len32;
                    n_byte_min = r_in_len;
                    n_byte_max = r_in_len;
                end else begin
                    n_byte_sum = r_byte_sum + len32;
                    if (r_in_len < r_byte_min) begin
                        n_byte_min = r_in_len;
                    end else if (r_in_len > r_byte_max) begin
                        n_byte_max = r_in_len;
                    end
                end
            end
            if (r_en_gaps) begin
                n_last_arr = now;
                if (!first) begin
                    if (r_gap_sum == '0) begin
                        n_gap_sum = gap;
                        n_gap_min = gap;
                        n_gap_max = gap;
                    end else begin
                        n_gap_sum = r_gap_sum + gap;
                        if (gap < r_gap_min) begin
                            n_gap_min = gap;
                        end else if (gap > r_gap_max) begin
                            n_gap_max = gap;
                        end
                    end
                end
            end
            if (r_en_bursts) begin
                if (r_open_start == '0
                    || (r_open_active && (now - r_open_latest) >= r_long_gap)
                    || (!r_open_active && (now - r_open_start) >= r_short_gap)) begin
                    // close an active burst on the long gap, then open anew
                    if (r_open_start != '0 && r_open_active) begin
                        n_bst_count = e_bst_count;
                        n_size_sum  = e_size_sum;
                        n_size_min  = e_size_min;
                        n_size_max  = e_size_max;
                        n_time_sum  = e_time_sum;
                        n_time_min  = e_time_min;
                        n_time_max  = e_time_max;
                    end
                    n_open_start  = now;
                    n_open_latest = now;
                    n_open_size   = len32;
                    n_open_active = len32 > r_burst_threshold;
                end else begin
                    n_open_size   = grown;
                    n_open_latest = now;
                    if (!r_open_active && grown > r_burst_threshold) begin
                        n_open_active = 1'b1;
                    end
                end
            end
            n_pkt_count = r_pkt_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_count   <= '0;
            r_byte_sum    <= '0;
            r_byte_min    <= '0;
            r_byte_max    <= '0;
            r_last_arr    <= '0;
            r_gap_sum     <= '0;
            r_gap_min     <= '0;
            r_gap_max     <= '0;
            r_bst_count   <= '0;
            r_size_sum    <= '0;
            r_size_min    <= '0;
            r_size_max    <= '0;
            r_time_sum    <= '0;
            r_time_min    <= '0;
            r_time_max    <= '0;
            r_open_start  <= '0;
            r_open_latest <= '0;
            r_open_size   <= '0;
            r_open_active <= 1'b0;
        end else begin
            r_pkt_count   <= n_pkt_count;
            r_byte_sum    <= n_byte_sum;
            r_byte_min    <= n_byte_min;
            r_byte_max    <= n_byte_max;
            r_last_arr    <= n_last_arr;
            r_gap_sum     <= n_gap_sum;
            r_gap_min     <= n_gap_min;
            r_gap_max     <= n_gap_max;
            r_bst_count   <= n_bst_count;
            r_size_sum    <= n_size_sum;
            r_size_min    <= n_size_min;
            r_size_max    <= n_size_max;
            r_time_sum    <= n_time_sum;
            r_time_min    <= n_time_min;
            r_time_max    <= n_time_max;
            r_open_start  <= n_open_start;
            r_open_latest <= n_open_latest;
            r_open_size   <= n_open_size;
            r_open_active <= n_open_active;
        end
    end

    // readout values, open burst folded in
    always_comb begin
        w_vals[fssb_pkg::STAT_PACKETS]  = fssb_pkg::VAL_W'(r_pkt_count);
        w_vals[fssb_pkg::STAT_BYTE_SUM] = fssb_pkg::VAL_W'(r_byte_sum);
        w_vals[fssb_pkg::STAT_BYTE_MIN] = fssb_pkg::VAL_W'(r_byte_min);
        w_vals[fssb_pkg::STAT_BYTE_MAX] = fssb_pkg::VAL_W'(r_byte_max);
        w_vals[fssb_pkg::STAT_GAP_SUM]  = fssb_pkg::VAL_W'(r_gap_sum);
        w_vals[fssb_pkg::STAT_GAP_MIN]  = fssb_pkg::VAL_W'(r_gap_min);
        w_vals[fssb_pkg::STAT_GAP_MAX]  = fssb_pkg::VAL_W'(r_gap_max);
        w_vals[fssb_pkg::STAT_BURSTS]   = fssb_pkg::VAL_W'(e_bst_count);
        w_vals[fssb_pkg::STAT_SIZE_SUM] = fssb_pkg::VAL_W'(e_size_sum);
        w_vals[fssb_pkg::STAT_SIZE_MIN] = fssb_pkg::VAL_W'(e_size_min);
        w_vals[fssb_pkg::STAT_SIZE_MAX] = fssb_pkg::VAL_W'(e_size_max);
        w_vals[fssb_pkg::STAT_TIME_SUM] = fssb_pkg::VAL_W'(e_time_sum);
        w_vals[fssb_pkg::STAT_TIME_MIN] = fssb_pkg::VAL_W'(e_time_min);
        w_vals[fssb_pkg::STAT_TIME_MAX] = fssb_pkg::VAL_W'(e_time_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_busy <= 1'b0;
            r_rd_cnt  <= '0;
        end else if (w_close) begin
            r_rd_busy <= 1'b1;
            r_rd_cnt  <= '0;
        end else if (w_beat_out) begin
            if (r_rd_cnt == fssb_pkg::STAT_TIME_MAX) begin
                r_rd_busy <= 1'b0;
                r_rd_cnt  <= '0;
            end else begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
        end
    end

    // snapshot shift line, head is the current beat
    always_ff @(posedge i_clk) begin
        if (w_close) begin
            for (int k = 0; k < fssb_pkg::NUM_STATS; k++) begin
                r_snap[k] <= w_vals[k];
            end
        end else if (w_beat_out) begin
            for (int k = 0; k < fssb_pkg::NUM_STATS - 1; k++) begin
                r_snap[k] <= r_snap[k+1];
            end
        end
    end

    assign m_axis_tvalid = r_rd_busy;
    assign m_axis_tdata  = r_snap[0];
    assign m_axis_tuser  = r_rd_cnt;
    assign m_axis_tlast  = r_rd_cnt == fssb_pkg::STAT_TIME_MAX;

`ifndef SYNTHESIS
    a_idle_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rd_busy |-> r_rd_cnt == '0)
        else $error("readout counter moved while idle");

    a_close_starts_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> r_rd_busy && r_rd_cnt == '0)
        else $error("close did not start a readout");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> r_pkt_count == '0 && r_open_start == '0 && !r_open_active
                    && r_bst_count == '0)
        else $error("statistics not cleared after close");

    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_in_op == fssb_pkg::OP_CLOSE && r_rd_busy)
        else $error("input stalled without a pending close");
`endif

endmodule
